// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;
   localparam int XW = 10;
   localparam int CW = 20;
   localparam int TW = 16;
   localparam int SW = 3;
   localparam int OW = 9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [SW-1:0] ST_INSERTED  = 3'd0;
   localparam logic [SW-1:0] ST_REPLACED  = 3'd1;
   localparam logic [SW-1:0] ST_DISCARDED = 3'd2;
   localparam logic [SW-1:0] ST_FULL      = 3'd3;
   localparam logic [SW-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [CW-1:0] cost;
      logic [TW-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic          op;
      logic [XW-1:0] pos_x;
      logic [XW-1:0] pos_y;
      logic [CW-1:0] cost;
      logic [TW-1:0] node_tag;
   } req_type;

   typedef struct packed {
      logic [SW-1:0] status;
      logic          got_item;
      logic [XW-1:0] out_x;
      logic [XW-1:0] out_y;
      logic [CW-1:0] out_cost;
      logic [TW-1:0] out_tag;
      logic [OW-1:0] occupancy;
      logic          is_empty;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic done;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic last;
   } sts_type;
endpackage

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces of the queue.
`timescale 1ns / 1ps
interface spq_req_if import spq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/spq_datapath.sv =====
// Queue storage in shift cells, parallel compare and result register.
`timescale 1ns / 1ps
module spq_datapath import spq_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output sts_type sts,
   output rsp_type rsp_data
);
   localparam int NW = $clog2(CAPACITY + 1);

   entry_type     slot_ff [CAPACITY];
   logic [NW-1:0] count_ff, count_in;
   req_type       item_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [CAPACITY-1:0] live, hit, big, first_big, ins_mask, dup_first;
   logic                dup_any, big_any, full;

   // The walk stops at the first entry that matches coordinates or costs more.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live[i] = NW'(i) < count_ff;
         hit[i]  = live[i] && slot_ff[i].x == item_ff.pos_x && slot_ff[i].y == item_ff.pos_y;
         big[i]  = live[i] && item_ff.cost < slot_ff[i].cost;
      end
   end

   logic [CAPACITY-1:0] stop;
   assign stop      = hit | big;
   // Lowest stop position as one-hot.
   logic [CAPACITY-1:0] stop_1h;
   assign stop_1h   = stop & (~stop + 1'b1);
   assign dup_first = stop_1h & hit;
   assign first_big = stop_1h & ~hit;
   assign dup_any   = |dup_first;
   assign big_any   = |first_big;
   // Cells at or above the insertion point shift up by one.
   assign ins_mask  = big_any ? ~(first_big - 1'b1) : ~live;
   assign full      = count_ff == NW'(CAPACITY);

   logic dup_rep;
   entry_type dup_e;
   always_comb begin
      dup_e = '0;
      for (int i = 0; i < CAPACITY; i++)
         if (dup_first[i]) dup_e = slot_ff[i];
   end
   assign dup_rep = dup_e.cost > item_ff.cost;

   entry_type new_e;
   assign new_e = '{x: item_ff.pos_x, y: item_ff.pos_y, cost: item_ff.cost,
                    tag: item_ff.node_tag};

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.step) begin
         if (item_ff.op == OP_POP) begin
            if (count_ff != '0)
               for (int i = 0; i < CAPACITY - 1; i++) slot_ff[i] <= slot_ff[i+1];
         end else if (dup_any) begin
            for (int i = 0; i < CAPACITY; i++)
               if (dup_first[i] && dup_rep) slot_ff[i] <= new_e;
         end else if (!full) begin
            for (int i = 0; i < CAPACITY; i++)
               if (ins_mask[i]) begin
                  if (i == 0 || !ins_mask[(i == 0) ? 0 : i-1]) slot_ff[i] <= new_e;
                  else slot_ff[i] <= slot_ff[(i == 0) ? 0 : i-1];
               end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.step) begin
         if (item_ff.op == OP_POP) begin
            if (count_ff != '0) count_in = count_ff - 1'b1;
         end else if (!dup_any && !full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.occupancy = OW'(count_in);
      rsp_in.is_empty  = count_in == '0;
      if (item_ff.op == OP_POP) begin
         if (count_ff == '0) rsp_in.status = ST_EMPTY;
         else begin
            rsp_in.status   = ST_INSERTED;
            rsp_in.got_item = 1'b1;
            rsp_in.out_x    = slot_ff[0].x;
            rsp_in.out_y    = slot_ff[0].y;
            rsp_in.out_cost = slot_ff[0].cost;
            rsp_in.out_tag  = slot_ff[0].tag;
         end
      end else if (dup_any) begin
         rsp_in.status = dup_rep ? ST_REPLACED : ST_DISCARDED;
      end else begin
         rsp_in.status = full ? ST_FULL : ST_INSERTED;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) rsp_ff <= rsp_in;
   end

   assign sts.last = cmd.done;
   assign rsp_data = rsp_ff;
endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller: accept, update and result hand-off sequence.
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WORK = 2'd1;
   localparam logic [1:0] S_SEND = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_SEND;
   assign cmd.load  = req_valid && req_ready;
   assign cmd.step  = state_ff == S_WORK;
   assign cmd.done  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (cmd.load) state_in = S_WORK;
         S_WORK: state_in = S_SEND;
         S_SEND: if (sts.last) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== rtl/sorted_priority_queue_dedup.sv =====
// Sorted priority queue with coordinate dedup. Each item goes through accept, one
// parallel compare and shift of all cells, and result hand-off; a new item is
// accepted only after the result has been taken.
// Synchronous active-high reset empties the queue; entry contents are not cleared.
`timescale 1ns / 1ps
module sorted_priority_queue_dedup import spq_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic clock,
   input  logic reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   spq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .cmd,
      .req_data(req.data), .sts, .rsp_data(rsp.data)
   );
endmodule
